### hdl/tdse_pkg.sv
// Shared types and constants for the two-wire display serializer.
// Used by the front, back, top level and testbench; depends on nothing.
package tdse_pkg;

   localparam logic [1:0] ACT_COMMAND = 2'd0;
   localparam logic [1:0] ACT_DATA    = 2'd1;
   localparam logic [1:0] ACT_EMPTY   = 2'd2;

   localparam logic [7:0] DATA_CMD = 8'h40;

   localparam logic [2:0] BIT_LAST = 3'd7;
   localparam logic [1:0] SUB_ZERO = 2'd0;
   localparam logic [1:0] SUB_ONE  = 2'd1;
   localparam logic [1:0] SUB_LAST = 2'd2;

   typedef enum logic [1:0] {
      PH_START,
      PH_CMD,
      PH_DATA,
      PH_CLOSE
   } phase_type;

   typedef struct packed {
      logic       with_start;
      logic       with_cmd;
      logic       with_data;
      logic       with_end;
      logic [7:0] data_byte;
   } cmd_type;

   typedef struct packed {
      logic data_pin;
      logic clock_pin;
      logic last_step;
   } step_type;

endpackage

### hdl/two_wire_display_serializer.sv
// An accepted transfer is held in the command queue, and each pin step it makes is held in the
// result queue, before the step reaches the result ports. Throughput: one pin step per cycle from
// the back-end sequencer while a command waits and the result queue is not full.
// Reset (synchronous, active high) empties both queues and sets the back end's pin levels high.
// Depends on tdse_pkg, tdse_fifo, tdse_front and tdse_back.
module two_wire_display_serializer #(
   parameter int CMD_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_in_frame,
   input  logic       req_last_in_frame,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_data_pin,
   output logic       rsp_clock_pin,
   output logic       rsp_last_step
);

   localparam int CMD_W  = $bits(tdse_pkg::cmd_type);
   localparam int STEP_W = $bits(tdse_pkg::step_type);

   tdse_pkg::cmd_type  front_cmd, head_cmd;
   tdse_pkg::step_type back_step, rsp_step;
   logic [CMD_W-1:0]   head_bits;
   logic [STEP_W-1:0]  rsp_bits;
   logic               cmd_push, cmd_pop, cmd_empty;
   logic               step_push, step_full;

   tdse_front u_front (
      .req_push           (req_push),
      .req_action         (req_action),
      .req_data_byte      (req_data_byte),
      .req_first_in_frame (req_first_in_frame),
      .req_last_in_frame  (req_last_in_frame),
      .queue_full         (req_full),
      .cmd_push           (cmd_push),
      .cmd_entry          (front_cmd)
   );

   tdse_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .pop       (cmd_pop),
      .pop_data  (head_bits),
      .full      (req_full),
      .empty     (cmd_empty)
   );

   assign head_cmd = head_bits;

   tdse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_valid (!cmd_empty),
      .cmd_pop   (cmd_pop),
      .step      (back_step),
      .step_push (step_push),
      .step_full (step_full)
   );

   tdse_fifo #(
      .WIDTH (STEP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step_push),
      .push_data (back_step),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .full      (step_full),
      .empty     (rsp_empty)
   );

   assign rsp_step      = rsp_bits;
   assign rsp_data_pin  = rsp_step.data_pin;
   assign rsp_clock_pin = rsp_step.clock_pin;
   assign rsp_last_step = rsp_step.last_step;

endmodule

### hdl/tdse_fifo.sv
// Small first-in first-out queue of registers with full and empty flags.
// Generic; depends on nothing.
module tdse_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/tdse_front.sv
// Front end: accepts request transfers and turns each known action into a frame command.
// Depends on tdse_pkg for the action codes and the command type.
module tdse_front (
   input  logic              req_push,
   input  logic [1:0]        req_action,
   input  logic [7:0]        req_data_byte,
   input  logic              req_first_in_frame,
   input  logic              req_last_in_frame,
   input  logic              queue_full,
   output logic              cmd_push,
   output tdse_pkg::cmd_type cmd_entry
);

   logic known;

   always_comb begin
      cmd_entry.data_byte = req_data_byte;
      known = 1'b1;
      unique case (req_action)
         tdse_pkg::ACT_COMMAND: begin
            cmd_entry.with_start = 1'b1;
            cmd_entry.with_cmd   = 1'b0;
            cmd_entry.with_data  = 1'b1;
            cmd_entry.with_end   = 1'b1;
         end
         tdse_pkg::ACT_DATA: begin
            cmd_entry.with_start = req_first_in_frame;
            cmd_entry.with_cmd   = req_first_in_frame;
            cmd_entry.with_data  = 1'b1;
            cmd_entry.with_end   = req_last_in_frame;
         end
         tdse_pkg::ACT_EMPTY: begin
            cmd_entry.with_start = 1'b1;
            cmd_entry.with_cmd   = 1'b1;
            cmd_entry.with_data  = 1'b0;
            cmd_entry.with_end   = 1'b1;
         end
         default: begin
            cmd_entry.with_start = 1'b0;
            cmd_entry.with_cmd   = 1'b0;
            cmd_entry.with_data  = 1'b0;
            cmd_entry.with_end   = 1'b0;
            known = 1'b0;
         end
      endcase
      // An unused action code is taken and dropped without any pin steps.
      cmd_push = req_push && !queue_full && known;
   end

endmodule

### hdl/tdse_back.sv
// Back end: steps through the head frame command one pin change per cycle while the result queue has room.
// Depends on tdse_pkg for the phase, command and step types.
module tdse_back (
   input  logic               clock,
   input  logic               reset,
   input  tdse_pkg::cmd_type  cmd,
   input  logic               cmd_valid,
   output logic               cmd_pop,
   output tdse_pkg::step_type step,
   output logic               step_push,
   input  logic               step_full
);

   tdse_pkg::phase_type phase_ff, phase_in, phase, next_phase;
   logic       fresh_ff, fresh_in;
   logic [1:0] sub_ff, sub_in;
   logic [2:0] bit_ff, bit_in;
   logic       data_level_ff, data_level_in;
   logic       clock_level_ff, clock_level_in;
   logic       fire, phase_done, frame_done;
   logic [7:0] cur_byte;

   always_comb begin
      if (!fresh_ff) begin
         phase = phase_ff;
      end else if (cmd.with_start) begin
         phase = tdse_pkg::PH_START;
      end else if (cmd.with_cmd) begin
         phase = tdse_pkg::PH_CMD;
      end else begin
         phase = tdse_pkg::PH_DATA;
      end

      fire           = cmd_valid && !step_full;
      cur_byte       = (phase == tdse_pkg::PH_CMD) ? tdse_pkg::DATA_CMD : cmd.data_byte;
      data_level_in  = data_level_ff;
      clock_level_in = clock_level_ff;
      phase_done     = 1'b0;

      unique case (phase)
         tdse_pkg::PH_START: begin
            if (sub_ff == tdse_pkg::SUB_ZERO) begin
               data_level_in = 1'b0;
            end else begin
               clock_level_in = 1'b0;
               phase_done     = 1'b1;
            end
         end
         tdse_pkg::PH_CMD, tdse_pkg::PH_DATA: begin
            case (sub_ff)
               tdse_pkg::SUB_ZERO: data_level_in  = cur_byte[bit_ff];
               tdse_pkg::SUB_ONE:  clock_level_in = 1'b1;
               default: begin
                  clock_level_in = 1'b0;
                  phase_done     = (bit_ff == tdse_pkg::BIT_LAST);
               end
            endcase
         end
         tdse_pkg::PH_CLOSE: begin
            case (sub_ff)
               tdse_pkg::SUB_ZERO: data_level_in  = 1'b0;
               tdse_pkg::SUB_ONE:  clock_level_in = 1'b1;
               default: begin
                  data_level_in = 1'b1;
                  phase_done    = 1'b1;
               end
            endcase
         end
         default: phase_done = 1'b1;
      endcase

      frame_done = 1'b0;
      next_phase = phase;
      unique case (phase)
         tdse_pkg::PH_START: begin
            next_phase = cmd.with_cmd ? tdse_pkg::PH_CMD : tdse_pkg::PH_DATA;
         end
         tdse_pkg::PH_CMD: begin
            if (cmd.with_data) begin
               next_phase = tdse_pkg::PH_DATA;
            end else if (cmd.with_end) begin
               next_phase = tdse_pkg::PH_CLOSE;
            end else begin
               frame_done = 1'b1;
            end
         end
         tdse_pkg::PH_DATA: begin
            if (cmd.with_end) begin
               next_phase = tdse_pkg::PH_CLOSE;
            end else begin
               frame_done = 1'b1;
            end
         end
         default: frame_done = 1'b1;
      endcase

      phase_in = phase;
      fresh_in = 1'b0;
      sub_in   = sub_ff;
      bit_in   = bit_ff;
      if (phase_done) begin
         sub_in   = tdse_pkg::SUB_ZERO;
         bit_in   = '0;
         phase_in = next_phase;
         fresh_in = frame_done;
      end else if (sub_ff == tdse_pkg::SUB_LAST) begin
         sub_in = tdse_pkg::SUB_ZERO;
         bit_in = bit_ff + 1'b1;
      end else begin
         sub_in = sub_ff + 1'b1;
      end

      step.data_pin  = data_level_in;
      step.clock_pin = clock_level_in;
      step.last_step = phase_done && frame_done;
      step_push      = fire;
      cmd_pop        = fire && phase_done && frame_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= tdse_pkg::PH_START;
         fresh_ff       <= 1'b1;
         sub_ff         <= tdse_pkg::SUB_ZERO;
         bit_ff         <= '0;
         data_level_ff  <= 1'b1;
         clock_level_ff <= 1'b1;
      end else if (fire) begin
         phase_ff       <= phase_in;
         fresh_ff       <= fresh_in;
         sub_ff         <= sub_in;
         bit_ff         <= bit_in;
         data_level_ff  <= data_level_in;
         clock_level_ff <= clock_level_in;
      end
   end

endmodule

### hdl/tdse_checker.sv
// Port-level checks for the two-wire display serializer, bound to its top level.
// Depends only on the top level's ports.
module tdse_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_data_pin,
   input logic       rsp_clock_pin,
   input logic       rsp_last_step
);

   // Reset leaves the block ready for a transfer and with nothing to deliver.
   assert property (@(posedge clock) reset |=> !req_full && rsp_empty)
      else $error("queues not empty after reset");

   // A waiting result that is not taken stays on the ports unchanged.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty &&
         $stable({rsp_data_pin, rsp_clock_pin, rsp_last_step}))
      else $error("stalled result changed");

   // A final step with the clock high can only be the end condition, so data is high.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_last_step && rsp_clock_pin |-> rsp_data_pin)
      else $error("frame ended with data low");

   // An item accepted into an idle, empty block yields no result in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) && req_push && !req_full |-> rsp_empty)
      else $error("result appeared before any step was made");

endmodule

bind two_wire_display_serializer tdse_checker u_tdse_checker (
   .clock         (clock),
   .reset         (reset),
   .req_push      (req_push),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_data_pin  (rsp_data_pin),
   .rsp_clock_pin (rsp_clock_pin),
   .rsp_last_step (rsp_last_step)
);

### tb/sv/two_wire_display_serializer_test.sv
// Self-checking testbench for the two-wire display serializer: directed and random
// transfers are pushed in, and every pin step popped out is compared with a predictor.
// Depends on tdse_pkg and the two_wire_display_serializer top level.
`timescale 1ns / 1ps

module two_wire_display_serializer_test;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int IDLE_PERCENT = 36;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 100;
   localparam int DRAIN_CYCLES = 20;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [1:0] req_action;
   logic [7:0] req_data_byte;
   logic       req_first_in_frame;
   logic       req_last_in_frame;
   logic       rsp_empty;
   logic       rsp_pop;
   logic       rsp_data_pin;
   logic       rsp_clock_pin;
   logic       rsp_last_step;

   tdse_pkg::step_type expected_steps[$];
   tdse_pkg::step_type held_step;
   bit       have_held_step;
   logic     line_data = 1'b1;
   logic     line_clock = 1'b1;

   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_rsp_request = 1'b0;
   int step_errors = 0;
   int stall_cycles = 0;

   two_wire_display_serializer uut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_action(req_action),
      .req_data_byte(req_data_byte),
      .req_first_in_frame(req_first_in_frame),
      .req_last_in_frame(req_last_in_frame),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data_pin(rsp_data_pin),
      .rsp_clock_pin(rsp_clock_pin),
      .rsp_last_step(rsp_last_step)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function void record_step();
      if (have_held_step)
         expected_steps.push_back(held_step);
      held_step.data_pin = line_data;
      held_step.clock_pin = line_clock;
      held_step.last_step = 1'b0;
      have_held_step = 1'b1;
   endfunction

   function void set_data_line(input logic level);
      line_data = level;
      record_step();
   endfunction

   function void set_clock_line(input logic level);
      line_clock = level;
      record_step();
   endfunction

   function void start_condition();
      set_data_line(1'b0);
      set_clock_line(1'b0);
   endfunction

   function void end_condition();
      set_data_line(1'b0);
      set_clock_line(1'b1);
      set_data_line(1'b1);
   endfunction

   function void shift_byte(input logic [7:0] value);
      for (int i = 0; i < 8; i++) begin
         set_data_line(value[i]);
         set_clock_line(1'b1);
         set_clock_line(1'b0);
      end
   endfunction

   function void predict_pin_steps(input logic [1:0] action, input logic [7:0] value,
                                   input logic first, input logic last);
      have_held_step = 1'b0;
      case (action)
         tdse_pkg::ACT_COMMAND: begin
            start_condition();
            shift_byte(value);
            end_condition();
         end
         tdse_pkg::ACT_DATA: begin
            if (first) begin
               start_condition();
               shift_byte(tdse_pkg::DATA_CMD);
            end
            shift_byte(value);
            if (last)
               end_condition();
         end
         tdse_pkg::ACT_EMPTY: begin
            start_condition();
            shift_byte(tdse_pkg::DATA_CMD);
            end_condition();
         end
         default: begin
         end
      endcase
      if (have_held_step) begin
         held_step.last_step = 1'b1;
         expected_steps.push_back(held_step);
      end
   endfunction

   task automatic send_item(input logic [1:0] action, input logic [7:0] value,
                            input logic first, input logic last);
      @(negedge clock);
      while (req_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_action <= action;
      req_data_byte <= value;
      req_first_in_frame <= first;
      req_last_in_frame <= last;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      predict_pin_steps(action, value, first, last);
   endtask

   task automatic send_data_frame(input int length);
      for (int k = 0; k < length; k++)
         send_item(tdse_pkg::ACT_DATA, 8'($urandom), k == 0, k == length - 1);
   endtask

   task automatic test_command_frames();
      send_item(tdse_pkg::ACT_COMMAND, 8'h00, 1'b0, 1'b0);
      send_item(tdse_pkg::ACT_COMMAND, 8'hFF, 1'b1, 1'b1);
      send_item(tdse_pkg::ACT_COMMAND, 8'hA5, 1'b1, 1'b0);
      send_item(tdse_pkg::ACT_COMMAND, 8'h5A, 1'b0, 1'b1);
   endtask

   task automatic test_empty_frames();
      send_item(tdse_pkg::ACT_EMPTY, 8'hFF, 1'b1, 1'b1);
      send_item(tdse_pkg::ACT_EMPTY, 8'h00, 1'b0, 1'b0);
   endtask

   task automatic test_data_frames();
      send_item(tdse_pkg::ACT_DATA, 8'h81, 1'b1, 1'b1);
      send_item(tdse_pkg::ACT_DATA, 8'h00, 1'b1, 1'b0);
      send_item(tdse_pkg::ACT_DATA, 8'hFF, 1'b0, 1'b0);
      send_item(tdse_pkg::ACT_DATA, 8'h3C, 1'b0, 1'b1);
   endtask

   task automatic test_unusual_items();
      // The unused action code must produce no steps at all.
      send_item(ACT_UNUSED, 8'hFF, 1'b1, 1'b1);
      send_item(ACT_UNUSED, 8'h00, 1'b0, 1'b0);
      // A data byte outside a frame, then a frame left open and cut by a new start.
      send_item(tdse_pkg::ACT_DATA, 8'hC3, 1'b0, 1'b0);
      send_item(tdse_pkg::ACT_DATA, 8'h7E, 1'b1, 1'b0);
      send_item(tdse_pkg::ACT_COMMAND, 8'h01, 1'b0, 1'b0);
      send_item(tdse_pkg::ACT_DATA, 8'h18, 1'b0, 1'b1);
   endtask

   task automatic test_back_pressure();
      req_idle_on = 1'b0;
      hold_rsp_request = 1'b1;
      for (int n = 0; n < 8; n++)
         send_item(n[0] ? tdse_pkg::ACT_COMMAND : tdse_pkg::ACT_DATA,
                   8'($urandom), n == 0, n == 6);
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int sent;
      int pick;
      int length;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         req_idle_on = !(sent >= 40 && sent < 70);
         rsp_idle_on = req_idle_on;
         pick = $urandom_range(99);
         if (pick < 25) begin
            send_item(tdse_pkg::ACT_COMMAND, 8'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 40) begin
            send_item(tdse_pkg::ACT_EMPTY, 8'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 85) begin
            length = $urandom_range(1, 4);
            send_data_frame(length);
            sent += length;
         end else if (pick < 93) begin
            send_item(tdse_pkg::ACT_DATA, 8'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end else begin
            send_item(ACT_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
         end
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin : result_drain
      int hold_left;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            rsp_pop <= 1'b0;
            hold_left = RSP_HOLD_CYCLES;
            while (hold_left > 0) begin
               @(negedge clock);
               hold_left--;
            end
         end else begin
            rsp_pop <= !(rsp_idle_on && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin : step_checker
      tdse_pkg::step_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_steps.size() == 0) begin
            step_errors++;
            if (step_errors <= 10)
               $display("Unexpected pin step: data=%0b clock=%0b last=%0b",
                        rsp_data_pin, rsp_clock_pin, rsp_last_step);
         end else begin
            want = expected_steps.pop_front();
            if (want.data_pin !== rsp_data_pin || want.clock_pin !== rsp_clock_pin ||
                want.last_step !== rsp_last_step) begin
               step_errors++;
               if (step_errors <= 10)
                  $display({"Pin step mismatch: expected data=%0b clock=%0b last=%0b, ",
                            "got data=%0b clock=%0b last=%0b"},
                           want.data_pin, want.clock_pin, want.last_step,
                           rsp_data_pin, rsp_clock_pin, rsp_last_step);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_action = tdse_pkg::ACT_COMMAND;
      req_data_byte = 8'h00;
      req_first_in_frame = 1'b0;
      req_last_in_frame = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_command_frames();
      test_empty_frames();
      test_data_frames();
      test_unusual_items();
      test_back_pressure();
      test_random_traffic();

      @(negedge clock);
      req_push <= 1'b0;
      while (expected_steps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (step_errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### sim.f
hdl/tdse_pkg.sv
hdl/tdse_fifo.sv
hdl/tdse_front.sv
hdl/tdse_back.sv
hdl/two_wire_display_serializer.sv
hdl/tdse_checker.sv
tb/sv/two_wire_display_serializer_test.sv
